FILE: src/mbd_pkg.sv
package mbd_pkg;

    // Button count and countdown width
    localparam int NUM_BUTTONS = 3;
    localparam int COUNT_WIDTH = 16;

    // Configuration port widths
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 16;

    // Register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DEBOUNCE_TICKS = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ACTIVE_LEVELS  = 2'd1;

    // Register reset values
    localparam logic [CFG_DATA_WIDTH-1:0] DEBOUNCE_TICKS_RST = 16'd20;
    localparam logic [NUM_BUTTONS-1:0]    ACTIVE_LEVELS_RST  = '0;

    // Per-button phase
    typedef enum logic [1:0] {
        PH_IDLE       = 2'd0,
        PH_DEBOUNCING = 2'd1,
        PH_ACTIVE     = 2'd2
    } phase_t;

    typedef logic [NUM_BUTTONS-1:0] btn_vec_t;
    typedef logic [COUNT_WIDTH-1:0] count_t;

endpackage

FILE: src/multi_button_debouncer.sv
// Channel | Direction | Handshake            | Payload
// in      | in        | in_valid / in_stall  | pin_levels
// out     | out       | out_valid / out_stall| press_events, release_events, pressed_now
// cfg     | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One beat per cycle sustained unless out_stall holds the result register.
// The pin register feeds the per-button phase logic, which loads the result register.
// rst_n (async, active low) puts every button in idle with a zero countdown and
// restores the register defaults. A stalled result holds in its register while the
// pin register still takes one more beat; in_stall rises only when both are full
// and the result is stalled.
module multi_button_debouncer (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [mbd_pkg::NUM_BUTTONS-1:0]      pin_levels,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [mbd_pkg::NUM_BUTTONS-1:0]      press_events,
    output logic [mbd_pkg::NUM_BUTTONS-1:0]      release_events,
    output logic [mbd_pkg::NUM_BUTTONS-1:0]      pressed_now,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [mbd_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [mbd_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);

    import mbd_pkg::*;

    // Configuration registers
    logic [CFG_DATA_WIDTH-1:0] debounce_ticks_reg;
    btn_vec_t                  active_levels_reg;

    // Input stage
    logic     in_valid_reg;
    btn_vec_t pin_reg;

    // Per-button state
    phase_t phase_reg  [NUM_BUTTONS];
    phase_t phase_next [NUM_BUTTONS];
    count_t count_reg  [NUM_BUTTONS];
    count_t count_next [NUM_BUTTONS];

    // Result stage
    logic     out_valid_reg;
    btn_vec_t press_reg;
    btn_vec_t release_reg;
    btn_vec_t now_reg;
    btn_vec_t press_next;
    btn_vec_t release_next;
    btn_vec_t now_next;

    logic     advance;
    btn_vec_t act;
    count_t   load_value;

    assign cfg_ready = 1'b1;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ticks_reg <= DEBOUNCE_TICKS_RST;
            active_levels_reg  <= ACTIVE_LEVELS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_DEBOUNCE_TICKS: debounce_ticks_reg <= cfg_data;
                CFG_ACTIVE_LEVELS:  active_levels_reg  <= NUM_BUTTONS'(cfg_data);
                default:            ;
            endcase
        end
    end

    // Handshake: the pin register moves on when the result register is free
    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !advance;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_valid && !in_stall)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            pin_reg <= pin_levels;
        end
    end

    // A button is active when its pin matches its pressed level
    assign act        = ~(pin_reg ^ active_levels_reg);
    assign load_value = COUNT_WIDTH'(debounce_ticks_reg);

    // Next phase and countdown
    always_comb
    begin
        for (int i = 0; i < NUM_BUTTONS; i++)
        begin
            phase_next[i] = phase_reg[i];
            count_next[i] = count_reg[i];
            case (phase_reg[i])
                PH_DEBOUNCING:
                begin
                    if (count_reg[i][COUNT_WIDTH-1:1] == '0)
                    begin
                        count_next[i] = '0;
                        phase_next[i] = act[i] ? PH_ACTIVE : PH_IDLE;
                    end
                    else
                    begin
                        count_next[i] = count_reg[i] - 1'b1;
                    end
                end
                PH_ACTIVE:
                begin
                    if (!act[i])
                    begin
                        phase_next[i] = PH_IDLE;
                    end
                end
                default:
                begin
                    if (act[i])
                    begin
                        count_next[i] = load_value;
                        phase_next[i] = PH_DEBOUNCING;
                    end
                    else
                    begin
                        phase_next[i] = PH_IDLE;
                    end
                end
            endcase
        end
    end

    // Event outputs
    always_comb
    begin
        for (int i = 0; i < NUM_BUTTONS; i++)
        begin
            press_next[i]   = (phase_reg[i] == PH_DEBOUNCING)
                              && (phase_next[i] == PH_ACTIVE);
            release_next[i] = (phase_reg[i] == PH_ACTIVE) && (phase_next[i] == PH_IDLE);
            now_next[i]     = (phase_next[i] == PH_ACTIVE);
        end
    end

    // State update, one tick per beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                phase_reg[i] <= PH_IDLE;
                count_reg[i] <= '0;
            end
        end
        else if (advance)
        begin
            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                phase_reg[i] <= phase_next[i];
                count_reg[i] <= count_next[i];
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            press_reg   <= press_next;
            release_reg <= release_next;
            now_reg     <= now_next;
        end
    end

    assign press_events   = press_reg;
    assign release_events = release_reg;
    assign pressed_now    = now_reg;

    // Countdown stays zero outside debouncing
    btn_vec_t stray_count;
    always_comb
    begin
        for (int i = 0; i < NUM_BUTTONS; i++)
        begin
            stray_count[i] = (phase_reg[i] != PH_DEBOUNCING) && (count_reg[i] != '0);
        end
    end

`ifndef NO_ASSERTIONS
    a_no_press_and_release: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((press_reg & release_reg) == '0))
        else $error("press and release on the same button in one beat");

    a_press_is_pressed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((press_reg & ~now_reg) == '0))
        else $error("press reported for a button not in active");

    a_release_not_pressed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((release_reg & now_reg) == '0))
        else $error("release reported for a button still active");

    a_count_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        stray_count == '0)
        else $error("countdown nonzero outside debouncing");

    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !advance) |=> (now_reg == $past(now_reg)))
        else $error("result changed without a beat");
`endif

endmodule

FILE: test/multi_button_debouncer_tb.sv
`timescale 1ns / 100ps

module multi_button_debouncer_tb;

    import mbd_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int IDLE_PCT    = 17;
    localparam int MAX_PRINTED = 30;

    typedef logic [CFG_INDEX_WIDTH-1:0] reg_index_t;
    typedef logic [CFG_DATA_WIDTH-1:0]  reg_data_t;

    // Indexes that decode to no register
    localparam reg_index_t CFG_SPARE_2 = 2'd2;
    localparam reg_index_t CFG_SPARE_3 = 2'd3;

    typedef struct packed {
        btn_vec_t press;
        btn_vec_t rel;
        btn_vec_t held;
    } button_events_t;

    typedef enum bit {ROW_PINS, ROW_REG} row_kind_t;

    typedef struct {
        row_kind_t      kind;
        reg_index_t     idx;
        reg_data_t      data;
        btn_vec_t       pins;
        bit             typed;
        button_events_t want;
    } stim_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    btn_vec_t   pin_levels = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    btn_vec_t   press_events;
    btn_vec_t   release_events;
    btn_vec_t   pressed_now;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    reg_index_t cfg_index = '0;
    reg_data_t  cfg_data = '0;

    // Predictor state and register copies
    phase_t    phase_q [NUM_BUTTONS];
    count_t    countdown_q [NUM_BUTTONS];
    reg_data_t ticks_q;
    btn_vec_t  levels_q;

    button_events_t expected_events [$];
    button_events_t due;
    stim_row_t      stim_rows [$];
    bit             quiet = 1'b0;
    int             mismatches = 0;
    int             results_seen = 0;
    int             cycle_count = 0;

    multi_button_debouncer dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .pin_levels     (pin_levels),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .press_events   (press_events),
        .release_events (release_events),
        .pressed_now    (pressed_now),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // One tick of every button machine
    function automatic button_events_t debounce_step(btn_vec_t pins);
        btn_vec_t       act;
        button_events_t ev;
        act = ~(pins ^ levels_q);
        ev = '0;
        for (int b = 0; b < NUM_BUTTONS; b++)
        begin
            case (phase_q[b])
                PH_DEBOUNCING:
                begin
                    // pin is only looked at once the countdown runs out
                    if (countdown_q[b] <= 1)
                    begin
                        countdown_q[b] = '0;
                        if (act[b])
                        begin
                            phase_q[b] = PH_ACTIVE;
                            ev.press[b] = 1'b1;
                        end
                        else
                            phase_q[b] = PH_IDLE;
                    end
                    else
                        countdown_q[b] = countdown_q[b] - 1'b1;
                end
                PH_ACTIVE:
                begin
                    if (!act[b])
                    begin
                        phase_q[b] = PH_IDLE;
                        ev.rel[b] = 1'b1;
                    end
                end
                default:
                begin
                    if (act[b])
                    begin
                        countdown_q[b] = count_t'(ticks_q);
                        phase_q[b] = PH_DEBOUNCING;
                    end
                    else
                        phase_q[b] = PH_IDLE;
                end
            endcase
            if (phase_q[b] == PH_ACTIVE)
                ev.held[b] = 1'b1;
        end
        return ev;
    endfunction

    function automatic stim_row_t pin_row(btn_vec_t pins, bit typed, button_events_t want);
        stim_row_t row;
        row.kind = ROW_PINS;
        row.idx = '0;
        row.data = '0;
        row.pins = pins;
        row.typed = typed;
        row.want = want;
        return row;
    endfunction

    function automatic stim_row_t reg_row(reg_index_t idx, reg_data_t data);
        stim_row_t row;
        row.kind = ROW_REG;
        row.idx = idx;
        row.data = data;
        row.pins = '0;
        row.typed = 1'b0;
        row.want = '0;
        return row;
    endfunction

    task automatic report_mismatch(string what, btn_vec_t got, btn_vec_t want);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("ERROR result %0d %s: got %b want %b", results_seen, what, got, want);
    endtask

    // Hold the sender off until every pending result is out
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_events.size() != 0)
            @(posedge clk);
    endtask

    // cfg_valid stays up after the beat; the next pin beat lowers it,
    // so back-to-back writes never lower and raise it in one step
    task automatic write_reg(reg_index_t idx, reg_data_t data);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_DEBOUNCE_TICKS: ticks_q = data;
            CFG_ACTIVE_LEVELS:  levels_q = data[NUM_BUTTONS-1:0];
            default: ;
        endcase
    endtask

    task automatic send_beat(btn_vec_t pins, bit typed, button_events_t want);
        button_events_t model_ev;
        cfg_valid <= 1'b0;
        while (!quiet && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        pin_levels <= pins;
        do
            @(posedge clk);
        while (in_stall);
        model_ev = debounce_step(pins);
        expected_events.push_back(typed ? want : model_ev);
    endtask

    // Mostly held levels with the odd glitch bit, some pure noise
    task automatic press_bounce_run(int beats);
        int       left;
        int       len;
        btn_vec_t hold;
        btn_vec_t pins;
        left = beats;
        while (left > 0)
        begin
            if ($urandom_range(99) < 80)
            begin
                hold = btn_vec_t'($urandom_range((1 << NUM_BUTTONS) - 1));
                len = $urandom_range(1, int'(ticks_q) + 4);
                for (int k = 0; k < len && left > 0; k++)
                begin
                    pins = hold;
                    if ($urandom_range(99) < 8)
                        pins[$urandom_range(NUM_BUTTONS - 1)] ^= 1'b1;
                    send_beat(pins, 1'b0, '0);
                    left--;
                end
            end
            else
            begin
                send_beat(btn_vec_t'($urandom_range((1 << NUM_BUTTONS) - 1)), 1'b0, '0);
                left--;
            end
        end
    endtask

    // Receiver stalls
    always @(posedge clk)
        out_stall <= quiet ? 1'b0 : ($urandom_range(99) < IDLE_PCT);

    // Result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_events.size() == 0)
                report_mismatch("beat with nothing pending, press", press_events, '0);
            else
            begin
                due = expected_events.pop_front();
                if (press_events !== due.press)
                    report_mismatch("press_events", press_events, due.press);
                if (release_events !== due.rel)
                    report_mismatch("release_events", release_events, due.rel);
                if (pressed_now !== due.held)
                    report_mismatch("pressed_now", pressed_now, due.held);
            end
            results_seen++;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("multi_button_debouncer: mismatch");
            $finish;
        end
    end

    initial
    begin
        for (int b = 0; b < NUM_BUTTONS; b++)
        begin
            phase_q[b] = PH_IDLE;
            countdown_q[b] = '0;
        end
        ticks_q = DEBOUNCE_TICKS_RST;
        levels_q = ACTIVE_LEVELS_RST;

        // Directed rows; typed results only where obvious
        // reset defaults: active low, so all-high pins do nothing
        stim_rows.push_back(pin_row(3'b111, 1'b1, {3'b000, 3'b000, 3'b000}));
        // writes to undecoded indexes are dropped
        stim_rows.push_back(reg_row(CFG_SPARE_2, 16'hFFFF));
        stim_rows.push_back(reg_row(CFG_SPARE_3, 16'h0001));
        stim_rows.push_back(pin_row(3'b111, 1'b1, {3'b000, 3'b000, 3'b000}));
        // zero debounce acts as one tick; upper level bits ignored
        stim_rows.push_back(reg_row(CFG_DEBOUNCE_TICKS, 16'd0));
        stim_rows.push_back(reg_row(CFG_ACTIVE_LEVELS, 16'hFFFA));
        stim_rows.push_back(pin_row(3'b010, 1'b1, {3'b000, 3'b000, 3'b000}));
        stim_rows.push_back(pin_row(3'b010, 1'b1, {3'b111, 3'b000, 3'b111}));
        stim_rows.push_back(pin_row(3'b101, 1'b1, {3'b000, 3'b111, 3'b000}));
        // bounce back before the sample
        stim_rows.push_back(pin_row(3'b010, 1'b0, '0));
        stim_rows.push_back(pin_row(3'b101, 1'b0, '0));
        // pin changes during debouncing are ignored
        stim_rows.push_back(reg_row(CFG_DEBOUNCE_TICKS, 16'd3));
        stim_rows.push_back(pin_row(3'b000, 1'b0, '0));
        stim_rows.push_back(pin_row(3'b111, 1'b0, '0));
        stim_rows.push_back(pin_row(3'b111, 1'b0, '0));
        stim_rows.push_back(pin_row(3'b000, 1'b0, '0));
        stim_rows.push_back(pin_row(3'b010, 1'b0, '0));
        stim_rows.push_back(pin_row(3'b101, 1'b0, '0));
        stim_rows.push_back(reg_row(CFG_ACTIVE_LEVELS, 16'h0007));
        stim_rows.push_back(pin_row(3'b111, 1'b0, '0));
        stim_rows.push_back(pin_row(3'b000, 1'b0, '0));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        foreach (stim_rows[r])
        begin
            if (stim_rows[r].kind == ROW_REG)
                write_reg(stim_rows[r].idx, stim_rows[r].data);
            else
                send_beat(stim_rows[r].pins, stim_rows[r].typed, stim_rows[r].want);
        end

        // Random phases over several settings
        write_reg(CFG_DEBOUNCE_TICKS, 16'd1);
        write_reg(CFG_ACTIVE_LEVELS, 16'($urandom));
        press_bounce_run(150);

        write_reg(CFG_DEBOUNCE_TICKS, 16'd3);
        write_reg(CFG_ACTIVE_LEVELS, 16'h0000);
        press_bounce_run(75);
        // let the pipe run dry mid-phase
        drain();
        press_bounce_run(75);

        write_reg(CFG_DEBOUNCE_TICKS, 16'd7);
        write_reg(CFG_ACTIVE_LEVELS, 16'h0007);
        press_bounce_run(150);

        // no idling on either side from here
        quiet = 1'b1;
        write_reg(CFG_DEBOUNCE_TICKS, 16'd2);
        write_reg(CFG_ACTIVE_LEVELS, 16'($urandom));
        press_bounce_run(150);

        // full-width countdown: hold all pressed well short of expiry, then let go
        write_reg(CFG_DEBOUNCE_TICKS, 16'hFFFF);
        write_reg(CFG_ACTIVE_LEVELS, 16'h0007);
        repeat (8) send_beat('1, 1'b0, '0);
        repeat (2) send_beat('0, 1'b0, '0);
        quiet = 1'b0;

        drain();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("multi_button_debouncer: match");
        else
            $display("multi_button_debouncer: mismatch");
        $finish;
    end

endmodule
